>>> rtl/core/fts_pkg.sv
// Package for the file type sniffer: type codes, signatures and shared types.
`default_nettype none
package fts_pkg;

  // Sampling spans for the text and comma/newline statistics.
  localparam int unsigned TEXT_SAMPLE = 1024;
  localparam int unsigned CSV_SAMPLE  = 100;

  // Header bytes kept: indexes 0..29 are all the classifier ever looks at.
  localparam int unsigned HDR_KEEP = 30;
  localparam int unsigned TAIL_LEN = 18;

  // Default depth of the record queue between front and back.
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  typedef enum logic [3:0] {
    FT_BINARY = 4'd0,
    FT_JSON   = 4'd1,
    FT_XML    = 4'd2,
    FT_CSV    = 4'd3,
    FT_TEXT   = 4'd4,
    FT_PDF    = 4'd5,
    FT_PNG    = 4'd6,
    FT_IMAGE  = 4'd7,
    FT_BMP    = 4'd8,
    FT_TGA    = 4'd9,
    FT_AUDIO  = 4'd10,
    FT_DOCX   = 4'd11
  } file_type_t;

  // Signatures, first byte in the most significant bits.
  localparam logic [63:0]  SIG_PNG  = 64'h89504E470D0A1A0A;
  localparam logic [127:0] SIG_TGA  = "TRUEVISION-XFILE";
  localparam logic [31:0]  SIG_ZIP  = 32'h504B0304;
  localparam logic [31:0]  SIG_PDF  = "%PDF";
  localparam logic [47:0]  SIG_GIF7 = "GIF87a";
  localparam logic [47:0]  SIG_GIF9 = "GIF89a";
  localparam logic [31:0]  SIG_RIFF = "RIFF";
  localparam logic [23:0]  SIG_ID3  = "ID3";
  localparam logic [39:0]  SIG_XML  = "<?xml";

  // Per-file record from the front: every test the classifier needs.
  typedef struct packed {
    logic short_file;
    logic text_like;
    logic json;
    logic xml;
    logic csv;
    logic pdf;
    logic png;
    logic jpeg;
    logic bmp;
    logic bmp24;
    logic tga;
    logic gif;
    logic riff;
    logic mp3;
    logic zip;
  } fts_flags_t;

endpackage
`default_nettype wire

>>> rtl/core/file_type_sniffer.sv
// Top level of the file type sniffer: front, record queue and back.
// Throughput: one byte per cycle, sustained while in_ready is high, including the last byte of each file.
// After the last byte's transaction the type code is registered in the queue and then
//   in the output register before out_valid rises.
// in_ready drops only while the queue holds QUEUE_DEPTH finished files behind a stalled output.
// Reset: synchronous, active high; clears counters, statistics, queue and output valid.
//   Header and tail stores are not cleared; each file overwrites what it reads.
`default_nettype none
module file_type_sniffer #(
  parameter int unsigned QUEUE_DEPTH = fts_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] type_code
);
  import fts_pkg::*;

  logic       take;
  logic       push;
  logic       q_full;
  logic       q_nonempty;
  logic       q_pop;
  fts_flags_t front_rec;
  fts_flags_t back_rec;

  // Take a byte whenever the queue has room for a finished file record.
  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  // Front: update stores and statistics, emit a record on the last byte.
  fts_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .push      (push),
    .flags     (front_rec)
  );

  // Queue: hold records so the front keeps streaming while the output stalls.
  fts_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_rec),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .pop_data  (back_rec)
  );

  // Back: decide the type code and present it as one output transaction.
  fts_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (q_nonempty),
    .rec       (back_rec),
    .rec_pop   (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .type_code (type_code)
  );

endmodule
`default_nettype wire

>>> rtl/core/fts_front.sv
// Front part: byte intake, header and tail stores, statistics, per-file tests.
`default_nettype none
module fts_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  output logic                 push,
  output fts_pkg::fts_flags_t  flags
);
  import fts_pkg::*;

  logic [7:0]  hdr      [HDR_KEEP];
  logic [7:0]  hdr_next [HDR_KEEP];
  logic [7:0]  tail      [TAIL_LEN];
  logic [7:0]  tail_next [TAIL_LEN];
  logic [31:0] byte_count;
  logic [31:0] byte_count_next;
  logic        text_like;
  logic        text_like_next;
  logic [1:0]  comma_tally;
  logic [1:0]  comma_tally_next;
  logic        newline_seen;
  logic        newline_seen_next;
  logic        in_text;
  logic        in_csv;
  logic        ctrl_byte;

  assign in_text   = byte_count < 32'(TEXT_SAMPLE);
  assign in_csv    = in_text && (byte_count < 32'(CSV_SAMPLE));
  assign ctrl_byte = (data_byte < 8'd32) && (data_byte != 8'h0A) && (data_byte != 8'h0D) &&
                     (data_byte != 8'h09) && (data_byte != 8'h00);

  always_comb begin
    for (int i = 0; i < HDR_KEEP; i++) begin
      hdr_next[i] = (byte_count == 32'(i)) ? data_byte : hdr[i];
    end
    for (int i = 0; i < TAIL_LEN - 1; i++) begin
      tail_next[i] = tail[i+1];
    end
    tail_next[TAIL_LEN-1] = data_byte;
  end

  always_comb begin
    byte_count_next   = (&byte_count) ? byte_count : byte_count + 32'd1;
    text_like_next    = text_like && !(in_text && ctrl_byte);
    comma_tally_next  = comma_tally;
    if (in_csv && (data_byte == ",") && (comma_tally != 2'd3)) begin
      comma_tally_next = comma_tally + 2'd1;
    end
    newline_seen_next = newline_seen || (in_csv && (data_byte == 8'h0A));
  end

  // Header and tail: payload, no reset.
  always_ff @(posedge clk) begin
    if (take) begin
      hdr  <= hdr_next;
      tail <= tail_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= '0;
      text_like    <= 1'b1;
      comma_tally  <= '0;
      newline_seen <= 1'b0;
    end else if (take) begin
      if (last_byte) begin
        byte_count   <= '0;
        text_like    <= 1'b1;
        comma_tally  <= '0;
        newline_seen <= 1'b0;
      end else begin
        byte_count   <= byte_count_next;
        text_like    <= text_like_next;
        comma_tally  <= comma_tally_next;
        newline_seen <= newline_seen_next;
      end
    end
  end

  // Tests on the file as it stands after this byte.
  always_comb begin
    logic png_m, tga_m, zip_m, pdf_m, gif7_m, gif9_m, riff_m, id3_m, xml_m;
    png_m = 1'b1; tga_m = 1'b1; zip_m = 1'b1; pdf_m = 1'b1; gif7_m = 1'b1;
    gif9_m = 1'b1; riff_m = 1'b1; id3_m = 1'b1; xml_m = 1'b1;
    for (int i = 0; i < 8; i++)  png_m  &= hdr_next[i] == SIG_PNG[63-8*i -: 8];
    for (int i = 0; i < 16; i++) tga_m  &= tail_next[i] == SIG_TGA[127-8*i -: 8];
    for (int i = 0; i < 4; i++)  zip_m  &= hdr_next[i] == SIG_ZIP[31-8*i -: 8];
    for (int i = 0; i < 4; i++)  pdf_m  &= hdr_next[i] == SIG_PDF[31-8*i -: 8];
    for (int i = 0; i < 6; i++)  gif7_m &= hdr_next[i] == SIG_GIF7[47-8*i -: 8];
    for (int i = 0; i < 6; i++)  gif9_m &= hdr_next[i] == SIG_GIF9[47-8*i -: 8];
    for (int i = 0; i < 4; i++)  riff_m &= hdr_next[i] == SIG_RIFF[31-8*i -: 8];
    for (int i = 0; i < 3; i++)  id3_m  &= hdr_next[i] == SIG_ID3[23-8*i -: 8];
    for (int i = 0; i < 5; i++)  xml_m  &= hdr_next[i] == SIG_XML[39-8*i -: 8];

    flags.short_file = byte_count_next < 32'd4;
    flags.text_like  = text_like_next;
    flags.json       = ((hdr_next[0] == "{") && (data_byte == "}")) ||
                       ((hdr_next[0] == "[") && (data_byte == "]"));
    flags.xml        = (byte_count_next >= 32'd5) && xml_m;
    flags.csv        = (comma_tally_next == 2'd3) && newline_seen_next;
    flags.pdf        = pdf_m;
    flags.png        = (byte_count_next >= 32'd8) && png_m;
    flags.jpeg       = (hdr_next[0] == 8'hFF) && (hdr_next[1] == 8'hD8);
    flags.bmp        = (byte_count_next >= 32'd54) && (hdr_next[0] == "B") &&
                       (hdr_next[1] == "M");
    flags.bmp24      = ({hdr_next[17], hdr_next[16], hdr_next[15], hdr_next[14]} == 32'd40) &&
                       ({hdr_next[29], hdr_next[28]} == 16'd24);
    flags.tga        = ((byte_count_next >= 32'd18) && (hdr_next[2] == 8'd2) &&
                        (hdr_next[16] == 8'd24)) ||
                       ((byte_count_next >= 32'd26) && tga_m);
    flags.gif        = (byte_count_next >= 32'd6) && (gif7_m || gif9_m);
    flags.riff       = riff_m;
    flags.mp3        = id3_m || ((hdr_next[0] == 8'hFF) && (hdr_next[1] == 8'hFB));
    flags.zip        = zip_m;
  end

  assign push = take && last_byte;

endmodule
`default_nettype wire

>>> rtl/core/fts_queue.sv
// Record queue between the front and the back.
`default_nettype none
module fts_queue #(
  parameter int unsigned DEPTH = fts_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  fts_pkg::fts_flags_t  push_data,
  output logic                 full,
  input  logic                 pop,
  output logic                 nonempty,
  output fts_pkg::fts_flags_t  pop_data
);
  import fts_pkg::*;

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  fts_flags_t    slots [DEPTH];
  logic [IW-1:0] wr_ptr;
  logic [IW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full     = count == CW'(DEPTH);
  assign nonempty = count != '0;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == IW'(DEPTH - 1)) ? '0 : wr_ptr + IW'(1);
      if (pop)  rd_ptr <= (rd_ptr == IW'(DEPTH - 1)) ? '0 : rd_ptr + IW'(1);
      if (push && !pop)      count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/fts_back.sv
// Back part: priority decision on a file record and the output register.
`default_nettype none
module fts_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rec_valid,
  input  fts_pkg::fts_flags_t  rec,
  output logic                 rec_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [3:0]           type_code
);
  import fts_pkg::*;

  file_type_t code;
  file_type_t code_reg;

  always_comb begin
    if (rec.short_file)    code = FT_BINARY;
    else if (rec.text_like) begin
      if (rec.json)        code = FT_JSON;
      else if (rec.xml)    code = FT_XML;
      else if (rec.csv)    code = FT_CSV;
      else                 code = FT_TEXT;
    end
    else if (rec.pdf)      code = FT_PDF;
    else if (rec.png)      code = FT_PNG;
    else if (rec.jpeg)     code = FT_IMAGE;
    else if (rec.bmp)      code = rec.bmp24 ? FT_BMP : FT_IMAGE;
    else if (rec.tga)      code = FT_TGA;
    else if (rec.gif)      code = FT_IMAGE;
    else if (rec.riff)     code = FT_AUDIO;
    else if (rec.mp3)      code = FT_AUDIO;
    else if (rec.zip)      code = FT_DOCX;
    else                   code = FT_BINARY;
  end

  // Refill the output register whenever it is empty or being drained.
  assign rec_pop = rec_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rec_pop) code_reg <= code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rec_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign type_code = code_reg;

endmodule
`default_nettype wire

>>> rtl/core/fts_checker.sv
// Port-level checker for the file type sniffer, bound to the top level.
`default_nettype none
module fts_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       last_byte,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] type_code
);
  import fts_pkg::*;

  logic [7:0] pending;
  logic       file_in;
  logic       file_out;

  assign file_in  = in_valid && in_ready && last_byte;
  assign file_out = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {7'd0, file_in} - {7'd0, file_out};
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(type_code))
    else $error("output transaction changed while stalled");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> type_code <= FT_DOCX)
    else $error("type code out of range");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 8'd0)
    else $error("result without a finished file");

endmodule

bind file_type_sniffer fts_checker u_fts_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .last_byte (last_byte),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .type_code (type_code)
);
`default_nettype wire

>>> tb/file_type_sniffer_tb.sv
// Self-checking testbench for the file type sniffer: whole files in, one type code out per file.
`default_nettype none
module file_type_sniffer_tb;
  import fts_pkg::*;

  // Stop once this many random bytes have gone in.
  localparam int RUN_BYTES   = 550;
  // Drop all idling on both sides past this random byte count.
  localparam int QUIET_AFTER = 400;
  // Cycles without any transaction before the run is declared hung.
  localparam int STALL_LIMIT = 1000;
  // Margin past the last expected result to catch a stray extra result.
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_REPORTS  = 10;

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_CTL = 8'h01;  // any control byte that marks a file as binary

  // File recipes. Binary noise (K_BIN) comes first, then text kinds; binary kinds from K_PDF on.
  typedef enum int {
    K_BIN, K_FILL00, K_FILLFF, K_TEXT, K_JSON_OBJ, K_JSON_ARR, K_XML, K_CSV, K_LATE,
    K_PDF, K_PNG, K_JPEG, K_BMP24, K_BMPX, K_TGA_HDR, K_TGA_FOOT, K_GIF7, K_GIF9,
    K_RIFF, K_ID3, K_MP3, K_ZIP, K_NUM
  } file_kind_t;

  typedef struct {
    file_kind_t kind;
    int         len;
    bit         typed;  // use the code in want instead of the sniffer model
    file_type_t want;
  } probe_row_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [3:0] type_code;

  // Sniffer model state: one file's worth of statistics.
  logic [7:0]  file_head [54];
  logic [7:0]  file_tail [18];
  logic [31:0] file_len;
  logic        looks_text;
  logic [1:0]  comma_cnt;
  logic        saw_newline;

  file_type_t expected_types [$];
  logic [7:0] file_buf [$];
  file_type_t head_type;

  int  fails;
  int  files_checked;
  int  bytes_sent;
  int  gap_chance;    // 0: no sender gaps in this file, else 1 in gap_chance bytes
  bit  quiet;         // end of run: no idling on either side
  int  stall_left;
  int  calm_left;
  int  idle_cycles;

  // Directed files: limits, each signature, and the near misses around them.
  probe_row_t probes [27] = '{
    '{K_BIN,        1, 1'b1, FT_BINARY},  // one byte is always too short
    '{K_BIN,        3, 1'b1, FT_BINARY},
    '{K_FILL00,     4, 1'b1, FT_TEXT},    // NUL still counts as text
    '{K_FILLFF,    60, 1'b1, FT_TEXT},
    '{K_JSON_OBJ,  12, 1'b1, FT_JSON},
    '{K_JSON_ARR,   4, 1'b1, FT_JSON},
    '{K_XML,        5, 1'b1, FT_XML},
    '{K_XML,        4, 1'b0, FT_BINARY},  // prolog cut short
    '{K_CSV,       48, 1'b0, FT_BINARY},
    '{K_TEXT,      30, 1'b0, FT_BINARY},
    '{K_LATE,     140, 1'b0, FT_BINARY},  // commas and newlines past the comma sample span
    '{K_PDF,       20, 1'b0, FT_BINARY},
    '{K_PDF,        4, 1'b1, FT_TEXT},    // printable signature alone reads as text
    '{K_PNG,        8, 1'b1, FT_PNG},
    '{K_JPEG,      12, 1'b0, FT_BINARY},
    '{K_BMP24,     54, 1'b0, FT_BINARY},
    '{K_BMPX,      70, 1'b0, FT_BINARY},
    '{K_BMP24,     53, 1'b0, FT_BINARY},  // one byte short of a full bitmap header
    '{K_TGA_HDR,   18, 1'b0, FT_BINARY},
    '{K_TGA_FOOT,  26, 1'b0, FT_BINARY},
    '{K_GIF7,      10, 1'b0, FT_BINARY},
    '{K_GIF9,       9, 1'b0, FT_BINARY},
    '{K_RIFF,      44, 1'b0, FT_BINARY},
    '{K_ID3,       10, 1'b0, FT_BINARY},
    '{K_MP3,       10, 1'b0, FT_BINARY},
    '{K_ZIP,       30, 1'b0, FT_BINARY},
    '{K_BIN,       16, 1'b0, FT_BINARY}
  };

  file_type_sniffer dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .type_code(type_code)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Compare the first n header bytes with a signature stored first byte in the MSBs.
  function automatic bit head_is(input logic [127:0] sig, input int n);
    for (int i = 0; i < n; i++) begin
      if (file_head[i] != sig[8*(n-1-i) +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit tail_has_footer();
    for (int i = 0; i < 16; i++) begin
      if (file_tail[i] != SIG_TGA[8*(15-i) +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Decide the type of a finished file. Length checks guard every header read.
  function automatic file_type_t classify(input logic [31:0] size, input logic [7:0] final_b);
    logic [7:0]  first;
    logic [31:0] dib;
    logic [15:0] bpp;
    first = file_head[0];
    dib   = {file_head[17], file_head[16], file_head[15], file_head[14]};
    bpp   = {file_head[29], file_head[28]};
    if (size < 32'd4) return FT_BINARY;
    if (looks_text) begin
      if ((first == "{" && final_b == "}") || (first == "[" && final_b == "]")) return FT_JSON;
      if (size >= 32'd5 && head_is(SIG_XML, 5)) return FT_XML;
      if (comma_cnt == 2'd3 && saw_newline) return FT_CSV;
      return FT_TEXT;
    end
    if (head_is(SIG_PDF, 4)) return FT_PDF;
    if (size >= 32'd8 && head_is(SIG_PNG, 8)) return FT_PNG;
    if (first == 8'hFF && file_head[1] == 8'hD8) return FT_IMAGE;
    if (size >= 32'd54 && first == "B" && file_head[1] == "M") begin
      return (dib == 32'd40 && bpp == 16'd24) ? FT_BMP : FT_IMAGE;
    end
    if ((size >= 32'd18 && file_head[2] == 8'd2 && file_head[16] == 8'd24) ||
        (size >= 32'd26 && tail_has_footer())) return FT_TGA;
    if (size >= 32'd6 && (head_is(SIG_GIF7, 6) || head_is(SIG_GIF9, 6))) return FT_IMAGE;
    if (head_is(SIG_RIFF, 4)) return FT_AUDIO;
    if (head_is(SIG_ID3, 3) || (first == 8'hFF && file_head[1] == 8'hFB)) return FT_AUDIO;
    if (head_is(SIG_ZIP, 4)) return FT_DOCX;
    return FT_BINARY;
  endfunction

  // Advance the model by one accepted byte; return 1 with the type on the last byte.
  function automatic bit sniff_byte(input logic [7:0] b, input logic fin,
                                    output file_type_t ft);
    logic [31:0] pos;
    pos = file_len;
    ft  = FT_BINARY;
    if (pos < 32'd54) file_head[pos] = b;
    for (int i = 0; i < 17; i++) file_tail[i] = file_tail[i+1];
    file_tail[17] = b;
    if (pos < TEXT_SAMPLE) begin
      if (b < 8'd32 && b != CH_LF && b != CH_CR && b != CH_TAB && b != 8'd0) begin
        looks_text = 1'b0;
      end
      if (pos < CSV_SAMPLE) begin
        if (b == "," && comma_cnt != 2'd3) comma_cnt++;
        if (b == CH_LF) saw_newline = 1'b1;
      end
    end
    if (file_len != 32'hFFFF_FFFF) file_len++;
    if (!fin) return 1'b0;
    ft = classify(file_len, b);
    // Clear the statistics so the next byte opens a new file.
    file_len    = '0;
    looks_text  = 1'b1;
    comma_cnt   = '0;
    saw_newline = 1'b0;
    return 1'b1;
  endfunction

  task automatic poke(input int at, input logic [7:0] v);
    if (at >= 0 && at < file_buf.size()) file_buf[at] = v;
  endtask

  task automatic put_sig(input logic [127:0] sig, input int n, input int at);
    for (int i = 0; i < n; i++) poke(at + i, sig[8*(n-1-i) +: 8]);
  endtask

  // Fill file_buf with one file of the given recipe and length.
  task automatic build_file(input file_kind_t kind, input int len);
    logic [7:0] b;
    int         r;
    file_buf.delete();
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 31);
      case (kind)
        K_FILL00: b = 8'h00;
        K_FILLFF: b = 8'hFF;
        K_TEXT, K_JSON_OBJ, K_JSON_ARR, K_XML: begin
          b = (r == 0) ? CH_LF : (r == 1) ? CH_TAB : (r == 2) ? CH_CR :
              8'($urandom_range(32, 126));
        end
        K_CSV: begin
          b = (r < 8) ? "," : (r == 8) ? CH_LF : 8'($urandom_range(32, 126));
        end
        K_LATE: begin
          // Plain letters first, then separators the sampler must ignore.
          if (i < CSV_SAMPLE) b = 8'($urandom_range(97, 122));
          else if (i < TEXT_SAMPLE) b = (r < 8) ? "," : (r == 8) ? CH_LF : "x";
          else b = CH_CTL;
        end
        default: b = 8'($urandom_range(0, 255));
      endcase
      file_buf.push_back(b);
    end
    case (kind)
      K_JSON_OBJ: begin
        poke(0, "{");
        poke(len - 1, "}");
      end
      K_JSON_ARR: begin
        poke(0, "[");
        poke(len - 1, "]");
      end
      K_XML:  put_sig(SIG_XML, 5, 0);
      K_PDF:  put_sig(SIG_PDF, 4, 0);
      K_PNG:  put_sig(SIG_PNG, 8, 0);
      K_JPEG: begin
        poke(0, 8'hFF);
        poke(1, 8'hD8);
      end
      K_BMP24, K_BMPX: begin
        poke(0, "B");
        poke(1, "M");
        poke(14, (kind == K_BMPX && $urandom_range(0, 1)) ? 8'd124 : 8'd40);
        poke(15, 8'd0);
        poke(16, 8'd0);
        poke(17, 8'd0);
        poke(28, (kind == K_BMPX && $urandom_range(0, 1)) ? 8'd32 : 8'd24);
        poke(29, 8'd0);
      end
      K_TGA_HDR: begin
        poke(2, 8'd2);
        poke(16, 8'd24);
      end
      K_TGA_FOOT: begin
        put_sig(SIG_TGA, 16, len - 18);
        poke(len - 2, ".");
        poke(len - 1, 8'd0);
      end
      K_GIF7: put_sig(SIG_GIF7, 6, 0);
      K_GIF9: put_sig(SIG_GIF9, 6, 0);
      K_RIFF: put_sig(SIG_RIFF, 4, 0);
      K_ID3:  put_sig(SIG_ID3, 3, 0);
      K_MP3: begin
        poke(0, 8'hFF);
        poke(1, 8'hFB);
      end
      K_ZIP:  put_sig(SIG_ZIP, 4, 0);
      default: ;
    endcase
    // Force binary files longer than eight bytes off the text path with a control byte at the end.
    if ((kind == K_BIN || kind >= K_PDF) && len > 8) poke(len - 1, CH_CTL);
  endtask

  // Send file_buf byte by byte and queue the type each finished file should give.
  task automatic send_file(input bit typed, input file_type_t want);
    int         n;
    bit         done;
    file_type_t ft;
    n = file_buf.size();
    for (int i = 0; i < n; i++) begin
      // Insert a sender gap now and then; valid only drops between transactions.
      if (gap_chance != 0 && !quiet && $urandom_range(1, gap_chance) == 1) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      in_valid  <= 1'b1;
      data_byte <= file_buf[i];
      last_byte <= (i == n - 1);
      // Hold the byte until the block takes it.
      do @(posedge clk); while (!in_ready);
      done = sniff_byte(file_buf[i], i == n - 1, ft);
      if (done) expected_types.push_back(typed ? want : ft);
      bytes_sent++;
    end
  endtask

  // Receiver: stall in bursts, with calm stretches in between.
  always @(posedge clk) begin
    if (rst || quiet) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (calm_left > 0) begin
      calm_left <= calm_left - 1;
      out_ready <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 17) - 1;
      calm_left  <= $urandom_range(0, 80);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Check each result transaction against the oldest expected type.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_types.size() == 0) begin
        fails++;
        if (fails <= MAX_REPORTS) $display("unexpected result: got %0d", type_code);
      end else begin
        head_type = expected_types.pop_front();
        if (type_code !== head_type) begin
          fails++;
          if (fails <= MAX_REPORTS) begin
            $display("file %0d: expected type %0d, got %0d",
                     files_checked, head_type, type_code);
          end
        end
      end
      files_checked++;
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    file_kind_t kind;
    int         len;
    rst         = 1'b1;
    in_valid    = 1'b0;
    data_byte   = 8'h00;
    last_byte   = 1'b0;
    quiet       = 1'b0;
    gap_chance  = 0;
    fails       = 0;
    files_checked = 0;
    bytes_sent  = 0;
    stall_left  = 0;
    calm_left   = 0;
    idle_cycles = 0;
    file_len    = '0;
    looks_text  = 1'b1;
    comma_cnt   = '0;
    saw_newline = 1'b0;
    foreach (file_head[i]) file_head[i] = '0;
    foreach (file_tail[i]) file_tail[i] = '0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed files.
    foreach (probes[i]) begin
      build_file(probes[i].kind, probes[i].len);
      gap_chance = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 12);
      send_file(probes[i].typed, probes[i].want);
    end

    // Hold the sender until every directed result is back.
    in_valid <= 1'b0;
    while (expected_types.size() != 0) @(posedge clk);

    // Random files: mostly well-formed signatures with random content,
    // some corrupted near the front, some plain noise.
    bytes_sent = 0;
    while (bytes_sent < RUN_BYTES) begin
      if (bytes_sent >= QUIET_AFTER) quiet <= 1'b1;
      kind = file_kind_t'($urandom_range(0, K_NUM - 1));
      if (kind == K_LATE && $urandom_range(0, 3) != 0) kind = K_TEXT;
      case (kind)
        K_BMP24, K_BMPX: begin
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 53) : $urandom_range(54, 72);
        end
        K_TGA_FOOT: len = $urandom_range(20, 48);
        K_LATE:     len = $urandom_range(100, 160);
        default: begin
          len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : $urandom_range(4, 40);
        end
      endcase
      build_file(kind, len);
      if ($urandom_range(0, 5) == 0) begin
        file_buf[$urandom_range(0, ((len < 30) ? len : 30) - 1)] = 8'($urandom_range(0, 255));
      end
      gap_chance = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 12);
      // Drain the pipe now and then before the next file.
      if ($urandom_range(0, 11) == 0) begin
        in_valid <= 1'b0;
        while (expected_types.size() != 0) @(posedge clk);
      end
      send_file(1'b0, FT_BINARY);
    end

    in_valid <= 1'b0;
    while (expected_types.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
